>>> design/julia_escape_time_pixel_defines.svh
// Assertion macros for the Julia escape-time pixel block.
// Used by the top level only; relies on clk_i and rst_ni being in scope.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Property must hold at every clock edge out of reset
`define JET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jet_pkg.sv
// Shared types and constants for the Julia escape-time pixel block.
// No dependencies; used by the interfaces, the axis mapper, the cells and the top level.
package jet_pkg;

  // Field widths
  localparam int COL_W   = 10;
  localparam int DIM_W   = 11;
  localparam int SCALE_W = 31;
  localparam int SEED_W  = 32;
  localparam int STEP_W  = 4;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;

  // Largest code the result field can carry
  localparam int STEP_MAX = 2 ** STEP_W - 1;

  // Fraction bits of the Q4.28 registers
  localparam int REG_FRAC = 28;

  // Register indexes on the configuration port
  typedef enum logic [CIDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PLANE_SCALE  = 3'd2,
    CFG_SEED_REAL    = 3'd3,
    CFG_SEED_IMAG    = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [DIM_W-1:0]          RST_WIDTH  = 11'd64;
  localparam logic [DIM_W-1:0]          RST_HEIGHT = 11'd32;
  localparam logic [SCALE_W-1:0]        RST_SCALE  = 31'd16777216;
  localparam logic signed [SEED_W-1:0]  RST_SEED_RE = -32'sd212064010;
  localparam logic signed [SEED_W-1:0]  RST_SEED_IM = 32'sd40265318;

  // Per-pixel control that moves along the cell chain with the data
  typedef struct packed {
    logic              valid;  // beat present in this stage
    logic              alive;  // not escaped yet
    logic              big;    // last z has a component with magnitude >= 2
    logic [STEP_W-1:0] step;   // escape index, 0 while alive
  } jet_ctl_t;

endpackage

>>> design/jet_if.sv
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on jet_pkg for the field widths.
interface jet_pix_if;
  logic                     valid;
  logic                     ready;
  logic [jet_pkg::COL_W-1:0] pixel_col;
  logic [jet_pkg::COL_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface jet_res_if;
  logic                      valid;
  logic                      ready;
  logic [jet_pkg::STEP_W-1:0] escape_step;

  modport source (output valid, output escape_step, input ready);
  modport sink   (input valid, input escape_step, output ready);
endinterface

>>> design/jet_axis.sv
// Maps one pixel coordinate onto its axis of the complex plane (two stages).
// Depends on jet_pkg for field widths and the register fraction.
module jet_axis #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [jet_pkg::COL_W-1:0]     pix_i,
  input  logic [jet_pkg::DIM_W-1:0]     size_i,
  input  logic [jet_pkg::SCALE_W-1:0]   scale_i,
  output logic signed [FRAC_BITS+3:0]   z0_o
);

  localparam int ZW     = FRAC_BITS + 4;
  localparam int OFF_W  = jet_pkg::DIM_W + 1;
  localparam int PROD_W = jet_pkg::SCALE_W + 1 + OFF_W;
  // offset is doubled, so the product carries REG_FRAC + 1 fraction bits
  localparam int SRC_FRAC = jet_pkg::REG_FRAC + 1;
  localparam int SH_L   = (FRAC_BITS >= SRC_FRAC) ? FRAC_BITS - SRC_FRAC : 0;
  localparam int SH_R   = (FRAC_BITS >= SRC_FRAC) ? 0 : SRC_FRAC - FRAC_BITS;
  localparam int VW     = PROD_W + SH_L;

  logic signed [OFF_W-1:0]  off;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [VW-1:0]     v;
  logic [VW-ZW:0]           hi;
  logic                     fits;
  logic signed [ZW-1:0]     z0_d, z0_q;

  // 2*pix - size, then times scale
  assign off    = $signed({1'b0, pix_i, 1'b0}) - $signed({1'b0, size_i});
  assign prod_d = PROD_W'($signed({1'b0, scale_i})) * PROD_W'(off);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Align to FRAC_BITS (floor on right shift), saturate to Q4
  assign v    = (VW'(prod_q) <<< SH_L) >>> SH_R;
  assign hi   = v[VW-1:ZW-1];
  assign fits = (&hi) | ~(|hi);
  assign z0_d = fits ? v[ZW-1:0] : {v[VW-1], {(ZW-1){~v[VW-1]}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q <= z0_d;
    end
  end

  assign z0_o = z0_q;

endmodule

>>> design/jet_cell.sv
// One iteration cell: squares z, checks the previous escape, forms z*z + c.
// Depends on jet_pkg for the control struct and step width.
module jet_cell #(
  parameter int FRAC_BITS = 28,
  parameter int IDX       = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+3:0] cr_i,
  input  logic signed [FRAC_BITS+3:0] ci_i,
  input  jet_pkg::jet_ctl_t           ctl_i,
  input  logic signed [FRAC_BITS+3:0] zr_i,
  input  logic signed [FRAC_BITS+3:0] zi_i,
  output jet_pkg::jet_ctl_t           ctl_o,
  output logic signed [FRAC_BITS+3:0] zr_o,
  output logic signed [FRAC_BITS+3:0] zi_o
);

  localparam int ZW = FRAC_BITS + 4;   // cell input, |z| < 8
  localparam int PW = FRAC_BITS + 8;   // floored products, |p| <= 64
  localparam int NW = FRAC_BITS + 9;   // sums, |s| < 256
  // this cell checks the escape of the previous iteration
  localparam int CHK     = IDX - 1;
  localparam int CHK_SAT = (CHK > jet_pkg::STEP_MAX) ? jet_pkg::STEP_MAX : CHK;
  localparam logic [jet_pkg::STEP_W-1:0] CHK_STEP = jet_pkg::STEP_W'(CHK_SAT);
  localparam logic CHK_EN = (IDX > 1);
  localparam logic signed [NW-1:0] FOUR = NW'(64'd4 << FRAC_BITS);
  localparam logic signed [NW-1:0] TWO  = NW'(64'd2 << FRAC_BITS);
  localparam logic signed [NW-1:0] NTWO = -TWO;

  logic signed [2*ZW-1:0] m_rr, m_ii, m_ri;
  jet_pkg::jet_ctl_t      ctl1_q, ctl_d, ctl_q;
  logic signed [PW-1:0]   pr_q, pi_q, pm_q;
  logic signed [NW-1:0]   mag, nr, ni;
  logic                   esc, big_d;
  logic signed [ZW-1:0]   zr_q, zi_q;

  // Stage 1: exact products, floored by FRAC_BITS
  assign m_rr = zr_i * zr_i;
  assign m_ii = zi_i * zi_i;
  assign m_ri = zr_i * zi_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= m_rr[FRAC_BITS+PW-1:FRAC_BITS];
      pi_q <= m_ii[FRAC_BITS+PW-1:FRAC_BITS];
      pm_q <= m_ri[FRAC_BITS+PW-1:FRAC_BITS];
    end
  end

  // Stage 2: escape test on |z|^2, then next z
  assign mag = NW'(pr_q) + NW'(pi_q);
  assign esc = CHK_EN && (ctl1_q.big || (mag >= FOUR));
  assign nr  = NW'(pr_q) - NW'(pi_q) + NW'(cr_i);
  assign ni  = (NW'(pm_q) <<< 1) + NW'(ci_i);
  // a component at or past 2 guarantees escape at the next check
  assign big_d = (nr >= TWO) || (nr <= NTWO) || (ni >= TWO) || (ni <= NTWO);

  always_comb begin
    ctl_d     = ctl1_q;
    ctl_d.big = big_d;
    if (ctl1_q.alive && esc) begin
      ctl_d.alive = 1'b0;
      ctl_d.step  = CHK_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  // not big means both parts fit in (-2, 2); else the value is don't-care
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q <= nr[ZW-1:0];
      zi_q <= ni[ZW-1:0];
    end
  end

  assign ctl_o = ctl_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;

endmodule

>>> design/julia_escape_time_pixel.sv
// Julia escape-time pixel evaluator: takes one pixel per clock and returns
// the first iteration of z = z*z + c (z0 from the pixel position, c from the
// seed registers) whose |z|^2 reaches 4, or 0 if none of the ITERATIONS
// iterations escapes. The pipeline holds the coordinate mapping, then a row
// of ITERATIONS+1 cells of two stages each, one multiply stage and one add
// stage, the last cell only finishing the final escape check. One pixel
// enters every clock; a one-deep skid register at the output holds a
// result the sink does not take, and the whole row stalls while it is
// full. Configuration may be written only while no pixel is in flight.
module julia_escape_time_pixel #(
  parameter int ITERATIONS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  jet_pix_if.sink                       pix_i,
  jet_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [jet_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [jet_pkg::CFG_W-1:0]     cfg_data_i
);

`include "julia_escape_time_pixel_defines.svh"

  localparam int ZW   = FRAC_BITS + 4;
  localparam int NCEL = ITERATIONS + 1;
  localparam int CSHL = (FRAC_BITS >= jet_pkg::REG_FRAC) ? FRAC_BITS - jet_pkg::REG_FRAC : 0;
  localparam int CSHR = (FRAC_BITS >= jet_pkg::REG_FRAC) ? 0 : jet_pkg::REG_FRAC - FRAC_BITS;
  localparam int CW   = jet_pkg::SEED_W + CSHL;
  localparam int MAXS = (ITERATIONS > jet_pkg::STEP_MAX) ? jet_pkg::STEP_MAX : ITERATIONS;
  localparam logic [jet_pkg::STEP_W-1:0] MAX_STEP = jet_pkg::STEP_W'(MAXS);

  logic [jet_pkg::DIM_W-1:0]         width_q, height_q;
  logic [jet_pkg::SCALE_W-1:0]       scale_q;
  logic signed [jet_pkg::SEED_W-1:0] seed_re_q, seed_im_q;
  logic signed [CW-1:0]              cr_w, ci_w;
  logic signed [ZW-1:0]              cr, ci;

  logic                      adv;
  logic                      mv1_q, mv2_q;
  logic signed [ZW-1:0]      z0r, z0i;
  jet_pkg::jet_ctl_t         ctl [0:NCEL];
  logic signed [ZW-1:0]      zr  [0:NCEL];
  logic signed [ZW-1:0]      zi  [0:NCEL];
  jet_pkg::jet_ctl_t         last;

  logic                      skid_d, skid_q;
  logic [jet_pkg::STEP_W-1:0] skid_step_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= jet_pkg::RST_WIDTH;
      height_q  <= jet_pkg::RST_HEIGHT;
      scale_q   <= jet_pkg::RST_SCALE;
      seed_re_q <= jet_pkg::RST_SEED_RE;
      seed_im_q <= jet_pkg::RST_SEED_IM;
    end else if (cfg_we_i) begin
      unique case (jet_pkg::cfg_idx_e'(cfg_idx_i))
        jet_pkg::CFG_FRAME_WIDTH:  width_q   <= cfg_data_i[jet_pkg::DIM_W-1:0];
        jet_pkg::CFG_FRAME_HEIGHT: height_q  <= cfg_data_i[jet_pkg::DIM_W-1:0];
        jet_pkg::CFG_PLANE_SCALE:  scale_q   <= cfg_data_i[jet_pkg::SCALE_W-1:0];
        jet_pkg::CFG_SEED_REAL:    seed_re_q <= cfg_data_i[jet_pkg::SEED_W-1:0];
        jet_pkg::CFG_SEED_IMAG:    seed_im_q <= cfg_data_i[jet_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Seed in FRAC_BITS format (floor when dropping fraction bits)
  assign cr_w = (CW'(seed_re_q) <<< CSHL) >>> CSHR;
  assign ci_w = (CW'(seed_im_q) <<< CSHL) >>> CSHR;
  assign cr   = cr_w[ZW-1:0];
  assign ci   = ci_w[ZW-1:0];

  // Whole row advances unless the skid register holds a result
  assign adv         = ~skid_q;
  assign pix_i.ready = adv;

  // Coordinate mapping, two stages
  jet_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_re (
    .clk_i   (clk_i),
    .en_i    (adv),
    .pix_i   (pix_i.pixel_col),
    .size_i  (width_q),
    .scale_i (scale_q),
    .z0_o    (z0r)
  );

  jet_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_im (
    .clk_i   (clk_i),
    .en_i    (adv),
    .pix_i   (pix_i.pixel_row),
    .size_i  (height_q),
    .scale_i (scale_q),
    .z0_o    (z0i)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv1_q <= 1'b0;
      mv2_q <= 1'b0;
    end else if (adv) begin
      mv1_q <= pix_i.valid;
      mv2_q <= mv1_q;
    end
  end

  // Head of the cell row
  always_comb begin
    ctl[0]       = '0;
    ctl[0].valid = mv2_q;
    ctl[0].alive = 1'b1;
  end
  assign zr[0] = z0r;
  assign zi[0] = z0i;

  for (genvar k = 1; k <= NCEL; k++) begin : g_cell
    jet_cell #(.FRAC_BITS(FRAC_BITS), .IDX(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cr_i   (cr),
      .ci_i   (ci),
      .ctl_i  (ctl[k-1]),
      .zr_i   (zr[k-1]),
      .zi_i   (zi[k-1]),
      .ctl_o  (ctl[k]),
      .zr_o   (zr[k]),
      .zi_o   (zi[k])
    );
  end

  assign last = ctl[NCEL];

  // Output skid register
  always_comb begin
    if (skid_q) begin
      skid_d = ~res_o.ready;
    end else begin
      skid_d = last.valid & ~res_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      skid_step_q <= last.step;
    end
  end

  assign res_o.valid       = skid_q | last.valid;
  assign res_o.escape_step = skid_q ? skid_step_q : last.step;

  // Checks
  `JET_ASSERT_NEXT(a_skid_holds, skid_q && !res_o.ready,
                   skid_q && $stable(skid_step_q), "skid result lost while stalled")
  `JET_ASSERT_NEXT(a_skid_fill, !skid_q && last.valid && !res_o.ready,
                   skid_q, "stalled result not captured")
  `JET_ASSERT(a_alive_zero, !(last.valid && last.alive) || (last.step == '0),
              "unescaped pixel carries a nonzero step")
  `JET_ASSERT(a_step_range, !res_o.valid || (res_o.escape_step <= MAX_STEP),
              "escape step beyond iteration count")

endmodule
